/* rtl/bcs_pkg.sv */
// Shared types, widths and constants for the brightness / contrast /
// saturation pixel pipeline. No dependencies; imported by every rtl/bcs_* module.
package bcs_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS  = 12;          // gain fraction bits, 1.0 = 2^FRAC_BITS
    localparam int LUMA_BITS  = 12;          // luma weight fraction bits
    localparam int MID_SHIFT  = 7;           // mid gray 128 = 2^MID_SHIFT

    // Field widths
    localparam int NCH        = 3;
    localparam int CH_W       = 8;
    localparam int BRIGHT_W   = 13;
    localparam int GAIN_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int CV_W       = CH_W + 1;                   // channel minus mid gray
    localparam int A_W        = CV_W + GAIN_W + 1;          // mapped channel
    localparam int WP_W       = A_W + LUMA_BITS;            // weighted channel
    localparam int LUMA_W     = WP_W + 2;                   // luma sum
    localparam int DIFF_W     = LUMA_W + 1;                 // channel minus luma
    localparam int LO_W       = 20;                         // low slice of diff
    localparam int HI_W       = DIFF_W - LO_W;              // high slice of diff
    localparam int PL_W       = GAIN_W + LO_W;              // unsigned partial product
    localparam int PH_W       = GAIN_W + 1 + HI_W;          // signed partial product
    localparam int V_W        = PH_W + LO_W + 2;            // final scaled value
    localparam int OUT_SHIFT  = 2 * FRAC_BITS + LUMA_BITS;  // floor divide exponent

    // Pipeline stage positions
    localparam int NSTAGE     = 7;
    localparam int ST_A       = 0;   // contrast and brightness
    localparam int ST_WP      = 1;   // weighted channels
    localparam int ST_LUMA    = 2;   // luma sum
    localparam int ST_DIFF    = 3;   // channel minus luma
    localparam int ST_PART    = 4;   // saturation partial products
    localparam int ST_SUM     = 5;   // final scaled value
    localparam int ST_OUT     = 6;   // clamped output

    // Luma weights, red / green / blue, over 2^LUMA_BITS
    localparam logic [LUMA_BITS-1:0] LUMA_WEIGHT [NCH] = '{12'd1225, 12'd2404, 12'd467};

    // Reset value of every gain: 1.0
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHTNESS = 2'd0,
        REG_CONTRAST   = 2'd1,
        REG_SATURATION = 2'd2
    } t_cfg_reg;

    typedef logic [NCH-1:0][CH_W-1:0] t_rgb;
    typedef logic signed [A_W-1:0]    t_chan_a;
    typedef logic signed [LUMA_W-1:0] t_luma;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic [GAIN_W-1:0]   contrast;
        logic [GAIN_W-1:0]   saturation;
    } t_cfg;

    typedef struct packed {
        logic [NSTAGE-1:0] load;   // stage k takes the value of stage k-1
    } t_pipe_ctl;

endpackage

/* rtl/bcs_cfg.sv */
// Gain register file written through the configuration request channel.
// Depends on bcs_pkg.
module bcs_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bcs_pkg::t_cfg                    o_cfg
);
    import bcs_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness <= BRIGHT_W'(GAIN_ONE);
            r_cfg.contrast   <= GAIN_ONE;
            r_cfg.saturation <= GAIN_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_BRIGHTNESS: r_cfg.brightness <= i_cfg_data[BRIGHT_W-1:0];
                REG_CONTRAST:   r_cfg.contrast   <= i_cfg_data[GAIN_W-1:0];
                REG_SATURATION: r_cfg.saturation <= i_cfg_data[GAIN_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

endmodule

/* rtl/bcs_ctl.sv */
// Valid bits and load enables for the seven datapath stages.
// Depends on bcs_pkg.
module bcs_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bcs_pkg::t_pipe_ctl o_ctl
);
    import bcs_pkg::*;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] load;

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        load[NSTAGE-1] = !r_vld[NSTAGE-1] || !i_out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (load[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ctl.load  = load;
    assign o_in_stall  = !load[0];
    assign o_out_valid = r_vld[NSTAGE-1];

    // Requests in flight change only by what enters and what leaves.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(r_vld) == $countones($past(r_vld))
                + ($past(i_in_valid && !o_in_stall) ? 1 : 0)
                - ($past(o_out_valid && !i_out_stall) ? 1 : 0)))
        else $error("bcs_ctl: request count mismatch");

    // A full pipeline with a stalled output must stall the input.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && i_out_stall |-> o_in_stall)
        else $error("bcs_ctl: input open while pipeline full");

    // An accepted request lands in the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_vld[ST_A])
        else $error("bcs_ctl: accepted request lost");

endmodule

/* rtl/bcs_luma.sv */
// Front half: contrast and brightness per channel, weighted channels, luma sum.
// Depends on bcs_pkg; stages ST_A through ST_LUMA.
module bcs_luma (
    input  logic               i_clk,
    input  bcs_pkg::t_pipe_ctl i_ctl,
    input  bcs_pkg::t_cfg      i_cfg,
    input  bcs_pkg::t_rgb      i_rgb,
    output bcs_pkg::t_chan_a   o_a [bcs_pkg::NCH],
    output bcs_pkg::t_luma     o_luma
);
    import bcs_pkg::*;

    logic signed [CV_W-1:0] cv     [NCH];
    t_chan_a                n_a    [NCH];
    t_chan_a                r_a    [NCH];
    logic signed [WP_W-1:0] n_wp   [NCH];
    logic signed [WP_W-1:0] r_wp   [NCH];
    t_chan_a                r_a_wp [NCH];
    t_chan_a                r_a_lu [NCH];
    t_luma                  n_luma;
    t_luma                  r_luma;

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            cv[ch]   = $signed({1'b0, i_rgb[ch]}) - $signed(CV_W'(1 << MID_SHIFT));
            // (c - 128) * contrast + brightness * 128
            n_a[ch]  = A_W'(cv[ch]) * A_W'($signed({1'b0, i_cfg.contrast}))
                     + A_W'($signed({1'b0, i_cfg.brightness, MID_SHIFT'(0)}));
            n_wp[ch] = WP_W'(r_a[ch]) * WP_W'($signed({1'b0, LUMA_WEIGHT[ch]}));
        end
        n_luma = LUMA_W'(r_wp[0]) + LUMA_W'(r_wp[1]) + LUMA_W'(r_wp[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_A]) begin
            r_a <= n_a;
        end
        if (i_ctl.load[ST_WP]) begin
            r_wp   <= n_wp;
            r_a_wp <= r_a;
        end
        if (i_ctl.load[ST_LUMA]) begin
            r_luma <= n_luma;
            r_a_lu <= r_a_wp;
        end
    end

    assign o_a    = r_a_lu;
    assign o_luma = r_luma;

endmodule

/* rtl/bcs_sat.sv */
// Back half: saturation about luma, split multiply, final sum, floor and clamp.
// Depends on bcs_pkg; stages ST_DIFF through ST_OUT.
module bcs_sat (
    input  logic               i_clk,
    input  bcs_pkg::t_pipe_ctl i_ctl,
    input  bcs_pkg::t_cfg      i_cfg,
    input  bcs_pkg::t_chan_a   i_a [bcs_pkg::NCH],
    input  bcs_pkg::t_luma     i_luma,
    output bcs_pkg::t_rgb      o_rgb
);
    import bcs_pkg::*;

    logic signed [DIFF_W-1:0] n_diff   [NCH];
    logic signed [DIFF_W-1:0] r_diff   [NCH];
    t_luma                    r_luma_d;
    logic [PL_W-1:0]          n_pl     [NCH];
    logic [PL_W-1:0]          r_pl     [NCH];
    logic signed [PH_W-1:0]   n_ph     [NCH];
    logic signed [PH_W-1:0]   r_ph     [NCH];
    t_luma                    r_luma_p;
    logic signed [V_W-1:0]    n_v      [NCH];
    logic signed [V_W-1:0]    r_v      [NCH];
    t_rgb                     n_out;
    t_rgb                     r_out;

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            n_diff[ch] = (DIFF_W'(i_a[ch]) <<< LUMA_BITS) - DIFF_W'(i_luma);
            // saturation * diff as two partial products over the low and high slices
            n_pl[ch]   = PL_W'(i_cfg.saturation) * PL_W'(r_diff[ch][LO_W-1:0]);
            n_ph[ch]   = PH_W'($signed(r_diff[ch][DIFF_W-1:LO_W]))
                       * PH_W'($signed({1'b0, i_cfg.saturation}));
            n_v[ch]    = (V_W'(r_luma_p) <<< FRAC_BITS)
                       + (V_W'(r_ph[ch]) <<< LO_W)
                       + V_W'($signed({1'b0, r_pl[ch]}));
            // floor, then clamp to 0..255
            if (r_v[ch][V_W-1]) begin
                n_out[ch] = '0;
            end else if (|r_v[ch][V_W-2:OUT_SHIFT+CH_W]) begin
                n_out[ch] = '1;
            end else begin
                n_out[ch] = r_v[ch][OUT_SHIFT+CH_W-1:OUT_SHIFT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_DIFF]) begin
            r_diff   <= n_diff;
            r_luma_d <= i_luma;
        end
        if (i_ctl.load[ST_PART]) begin
            r_pl     <= n_pl;
            r_ph     <= n_ph;
            r_luma_p <= r_luma_d;
        end
        if (i_ctl.load[ST_SUM]) begin
            r_v <= n_v;
        end
        if (i_ctl.load[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_rgb = r_out;

endmodule

/* rtl/pixel_brightness_contrast_saturation.sv */
// Top level of the RGB brightness / contrast / saturation adjust pipeline.
// Depends on bcs_pkg, bcs_cfg, bcs_ctl, bcs_luma and bcs_sat.
//
//   Channel   Handshake                     Payload
//   --------  ----------------------------  ---------------------------------------
//   pixel in  i_in_valid  / o_in_stall      i_red_in, i_green_in, i_blue_in (8b)
//   pixel out o_out_valid / i_out_stall     o_red_out, o_green_out, o_blue_out (8b)
//   config    i_cfg_valid / o_cfg_ready     i_cfg_index (2b), i_cfg_data (16b)
//
// Throughput is one pixel per clock while the output is not stalled; the stages are
// mapped channel, weighted channels, luma, difference, partial products, sum, clamp.
// Reset is synchronous and active low; it empties the pipeline and sets all three
// gains to 1.0. An output stall holds the last stage and lets bubbles in earlier
// stages close up, so the input stalls only when every stage holds a pixel.
// Change gains only while no pixel is in flight.
module pixel_brightness_contrast_saturation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel in
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bcs_pkg::CH_W-1:0]        i_red_in,
    input  logic [bcs_pkg::CH_W-1:0]        i_green_in,
    input  logic [bcs_pkg::CH_W-1:0]        i_blue_in,
    // pixel out
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bcs_pkg::CH_W-1:0]        o_red_out,
    output logic [bcs_pkg::CH_W-1:0]        o_green_out,
    output logic [bcs_pkg::CH_W-1:0]        o_blue_out,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bcs_pkg::*;

    t_cfg      cfg;
    t_pipe_ctl ctl;
    t_rgb      rgb_in;
    t_rgb      rgb_out;
    t_chan_a   mapped [NCH];
    t_luma     luma;

    // Channel order everywhere: red, green, blue.
    assign rgb_in[0] = i_red_in;
    assign rgb_in[1] = i_green_in;
    assign rgb_in[2] = i_blue_in;

    // Gain registers.
    bcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Valid bits travel alongside the data; each stage loads when it can advance.
    bcs_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (ctl)
    );

    // Contrast about mid gray plus brightness offset, then luma of the result.
    bcs_luma u_luma (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (cfg),
        .i_rgb  (rgb_in),
        .o_a    (mapped),
        .o_luma (luma)
    );

    // Push each channel from or pull it toward luma, then floor and clamp.
    bcs_sat u_sat (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (cfg),
        .i_a    (mapped),
        .i_luma (luma),
        .o_rgb  (rgb_out)
    );

    assign o_red_out   = rgb_out[0];
    assign o_green_out = rgb_out[1];
    assign o_blue_out  = rgb_out[2];

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the pixel brightness / contrast / saturation pipeline.
// Drives RGB requests and gain writes, predicts each adjusted pixel in-bench and
// compares results in order. Depends on bcs_pkg and the pipeline RTL only.
`timescale 1ns / 100ps

module tb_top;
    import bcs_pkg::*;

    localparam int CYCLE_LIMIT     = 100000;
    localparam int LONG_HOLD       = 300;   // receiver hold-off, in cycles
    localparam int IDLE_PERCENT    = 15;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_PIXELS    = 150;
    // index past the last gain register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb_pixel;

    // DUT ports; every input is at a known value from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [CH_W-1:0]       i_red_in    = '0;
    logic [CH_W-1:0]       i_green_in  = '0;
    logic [CH_W-1:0]       i_blue_in   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CH_W-1:0]       o_red_out;
    logic [CH_W-1:0]       o_green_out;
    logic [CH_W-1:0]       o_blue_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Shadow copy of the gain registers, as the block holds them
    logic [BRIGHT_W-1:0]   bright_gain   = GAIN_ONE[BRIGHT_W-1:0];
    logic [GAIN_W-1:0]     contrast_gain = GAIN_ONE;
    logic [GAIN_W-1:0]     sat_gain      = GAIN_ONE;

    t_rgb_pixel            source_pixels[$];   // pixels waiting to be offered
    t_rgb_pixel            adjusted_q[$];      // adjusted pixels still owed by the block

    // Phase controls, written by the stimulus process with nonblocking updates
    logic                  send_idle_on  = 1'b0;
    logic                  recv_idle_on  = 1'b0;
    logic                  long_hold_go  = 1'b0;
    int                    hold_left     = 0;
    int                    cycle_count   = 0;
    int                    fail_count    = 0;

    pixel_brightness_contrast_saturation dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Adjust one pixel with the shadow gains. Every channel goes through
    // contrast about mid gray plus a brightness offset, then is pulled toward
    // or pushed away from the luma of the three mapped channels. Everything
    // stays exact until one floor at the end, so only the final value clamps.
    function automatic t_rgb_pixel adjust_pixel(input t_rgb_pixel px);
        longint          one;
        longint          mapped [NCH];
        longint          luma;
        longint          diff;
        longint          scaled;
        longint          floored;
        logic [CH_W-1:0] chan   [NCH];
        logic [CH_W-1:0] result [NCH];
        t_rgb_pixel      res;
        one     = longint'(1) << FRAC_BITS;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        luma    = 0;
        for (int k = 0; k < NCH; k++) begin
            mapped[k] = (longint'(chan[k]) - 128) * longint'(contrast_gain)
                      + 128 * one + (longint'(bright_gain) - one) * 128;
            luma += longint'(LUMA_WEIGHT[k]) * mapped[k];
        end
        for (int k = 0; k < NCH; k++) begin
            diff   = mapped[k] * (longint'(1) << LUMA_BITS) - luma;
            scaled = luma * one + longint'(sat_gain) * diff;
            if (scaled < 0) begin
                result[k] = '0;
            end else begin
                floored   = scaled >>> OUT_SHIFT;
                result[k] = (floored > 255) ? 8'd255 : floored[CH_W-1:0];
            end
        end
        res.red   = result[0];
        res.green = result[1];
        res.blue  = result[2];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Pixel driver: load the next pixel only when the bus is free or the
    // current request was just taken; a stalled request holds its payload.
    // The expected result is queued at load time, since gains never change
    // while pixels are in flight.
    always @(posedge i_clk) begin : pixel_driver
        t_rgb_pixel px;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (source_pixels.size() != 0 &&
                !(send_idle_on && $urandom_range(99) < IDLE_PERCENT)) begin
                px = source_pixels.pop_front();
                adjusted_q = {adjusted_q, adjust_pixel(px)};
                i_in_valid <= 1'b1;
                i_red_in   <= px.red;
                i_green_in <= px.green;
                i_blue_in  <= px.blue;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare every taken result with the oldest expectation,
    // then decide the stall for the next cycle (long hold-off or random).
    always @(posedge i_clk) begin : result_monitor
        t_rgb_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (adjusted_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel %0d/%0d/%0d",
                                          o_red_out, o_green_out, o_blue_out));
            end else begin
                want = adjusted_q.pop_front();
                if (o_red_out !== want.red)
                    report_mismatch($sformatf("red %0d, want %0d", o_red_out, want.red));
                if (o_green_out !== want.green)
                    report_mismatch($sformatf("green %0d, want %0d",
                                              o_green_out, want.green));
                if (o_blue_out !== want.blue)
                    report_mismatch($sformatf("blue %0d, want %0d",
                                              o_blue_out, want.blue));
            end
        end
        if (long_hold_go)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        i_out_stall <= long_hold_go || hold_left > 1 ||
                       (recv_idle_on && $urandom_range(99) < IDLE_PERCENT);
    end

    // Watchdog: a stuck handshake ends the run here
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[pixel_brightness_contrast_saturation] ERROR");
            $finish;
        end
    end

    // Write one gain register and mirror the write in the shadow copy.
    // Only call while nothing is in flight.
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_BRIGHTNESS: bright_gain   = data[BRIGHT_W-1:0];
            REG_CONTRAST:   contrast_gain = data[GAIN_W-1:0];
            REG_SATURATION: sat_gain      = data[GAIN_W-1:0];
            default: ;     // drop writes past the last register
        endcase
    endtask

    task automatic write_all_gains(input logic [CFG_DATA_W-1:0] bright,
                                   input logic [CFG_DATA_W-1:0] contrast,
                                   input logic [CFG_DATA_W-1:0] sat);
        write_gain(REG_BRIGHTNESS, bright);
        write_gain(REG_CONTRAST, contrast);
        write_gain(REG_SATURATION, sat);
    endtask

    task automatic queue_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                               input logic [CH_W-1:0] b);
        t_rgb_pixel px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        source_pixels = {source_pixels, px};
    endtask

    // Hold until every owed pixel has come back, then let the pipe settle
    task automatic wait_drained();
        while (source_pixels.size() != 0 || adjusted_q.size() != 0)
            @(posedge i_clk);
        repeat (NSTAGE + 1) @(posedge i_clk);
    endtask

    // Half the time near unity so results stay in range; zero, all ones (upper bits
    // dropped) and raw words hit the clamps and the truncation.
    function automatic logic [CFG_DATA_W-1:0] random_gain_word();
        case ($urandom_range(9))
            0, 1:    return '0;
            2, 3:    return '1;
            4:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'((1 << FRAC_BITS) - 1024 + $urandom_range(2047));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] random_channel();
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
                0:       return 8'd0;
                1:       return 8'd255;
                2:       return 8'd127;
                default: return 8'd128;
            endcase
        end
        return CH_W'($urandom);
    endfunction

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gains: pixel passes through unchanged
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd128, 8'd128, 8'd128);
        queue_pixel(8'd255, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd255);
        queue_pixel(8'h55, 8'hAA, 8'h55);
        queue_pixel(8'hAA, 8'h55, 8'hAA);
        wait_drained();

        // Zero gains: every channel maps to 0, gray output
        write_all_gains('0, '0, '0);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd128);
        queue_pixel(8'd1, 8'd254, 8'd127);
        wait_drained();

        // All ones: upper bits dropped, full gains, negative and overflowing results
        write_all_gains('1, '1, '1);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd128);
        queue_pixel(8'd1, 8'd254, 8'd127);
        wait_drained();

        // Unused index must not disturb the gains; max contrast, saturation zero
        write_gain(REG_UNUSED, 16'hA5A5);
        write_all_gains(CFG_DATA_W'(1 << FRAC_BITS), '1, '0);
        write_gain(REG_UNUSED, '0);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd128);
        queue_pixel(8'd1, 8'd254, 8'd127);
        wait_drained();

        // Random phases: new gains each time, sender pauses until drained
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_all_gains(random_gain_word(), random_gain_word(), random_gain_word());
            if ($urandom_range(3) == 0)
                write_gain(REG_UNUSED, CFG_DATA_W'($urandom));
            // first phase runs flat out; the rest idle at random
            send_idle_on <= (phase != 0);
            recv_idle_on <= (phase != 0);
            for (int n = 0; n < PHASE_PIXELS; n++)
                queue_pixel(random_channel(), random_channel(), random_channel());
            if (phase == 1) begin
                // long receiver hold-off so the pipe fills and stalls its input
                @(posedge i_clk);
                long_hold_go <= 1'b1;
                @(posedge i_clk);
                long_hold_go <= 1'b0;
            end
            wait_drained();
        end

        repeat (2 * NSTAGE) @(posedge i_clk);
        if (fail_count == 0 && adjusted_q.size() == 0) begin
            $display("[pixel_brightness_contrast_saturation] OK");
        end else begin
            $display("[pixel_brightness_contrast_saturation] ERROR");
        end
        $finish;
    end

endmodule
